[rtl/core/pkhm_pkg.sv]
// ----------------------------------------------------------------------------
// pkhm_pkg
// Shared types, status codes and hash function for the pointer key hash map.
// ----------------------------------------------------------------------------
package pkhm_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 1024;
    localparam int unsigned KEY_W           = 32;
    localparam int unsigned VAL_W           = 32;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [VAL_W-1:0] t_val;
    typedef logic [1:0]       t_status;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_MISS     = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_ZERO_KEY = 2'd3;

    // home slot mix before masking to the table size
    function automatic t_key hash_mix(input t_key key);
        return (key >> 2) ^ (key >> 14);
    endfunction

endpackage

[rtl/core/pkhm_if.sv]
// ----------------------------------------------------------------------------
// pkhm_cmd_if / pkhm_rsp_if
// Valid/ready channels carrying one command word and one response word.
// ----------------------------------------------------------------------------
interface pkhm_cmd_if;
    import pkhm_pkg::*;

    logic valid;
    logic ready;
    logic cmd;
    t_key key;
    t_val value;

    modport source (output valid, output cmd, output key, output value, input ready);
    modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface pkhm_rsp_if;
    import pkhm_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_val    found_value;

    modport source (output valid, output status, output found_value, input ready);
    modport sink   (input valid, input status, input found_value, output ready);
endinterface

[rtl/core/pointer_key_hash_map_unit.sv]
// ----------------------------------------------------------------------------
// pointer_key_hash_map_unit
// Linear probing map from 32-bit keys to 32-bit values, one probe unit
// stepped by a small sequencer over single-port key and value memories.
// ----------------------------------------------------------------------------
//  channel   dir  word fields
//  i_cmd     in   cmd, key, value
//  o_rsp     out  status, found_value
//
//  insert or lookup: each probe is a memory read step (S_READ) and a compare
//  step (S_CHECK) on the shared key port
//  zero key insert or insert into a full table: answered without a probe
//  after reset a clearing pass writes zero to every slot of the key memory,
//  i_cmd.ready is low meanwhile
//  a finished response waits in the output register; a stalled o_rsp holds
//  the sequencer only when a second response is ready to leave
// ----------------------------------------------------------------------------
module pointer_key_hash_map_unit #(
    parameter int unsigned TABLE_DEPTH = pkhm_pkg::DEF_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pkhm_cmd_if.sink    i_cmd,
    pkhm_rsp_if.source  o_rsp
);
    import pkhm_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = IDX_W + 1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_CHECK = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    localparam t_idx IDX_LAST = {IDX_W{1'b1}};
    localparam t_cnt CNT_FULL = CNT_W'(TABLE_DEPTH);

    // memories
    t_key mem_key [TABLE_DEPTH];
    t_val mem_val [TABLE_DEPTH];

    t_state  r_state,  n_state;
    t_idx    r_clr,    n_clr;
    t_idx    r_slot,   n_slot;
    t_idx    r_probes, n_probes;
    t_cnt    r_cnt,    n_cnt;
    logic    r_cmd,    n_cmd;
    t_key    r_key,    n_key;
    t_val    r_value,  n_value;
    t_status r_res_status, n_res_status;
    t_val    r_res_found,  n_res_found;
    logic    r_out_valid,  n_out_valid;
    t_status r_out_status, n_out_status;
    t_val    r_out_found,  n_out_found;
    t_key    r_rd_key;
    t_val    r_rd_val;

    logic key_we;
    t_idx key_wa;
    t_key key_wd;
    logic val_we;
    t_key mix;

    assign mix = hash_mix(i_cmd.key);

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_value = r_out_found;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_slot       = r_slot;
        n_probes     = r_probes;
        n_cnt        = r_cnt;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_value      = r_value;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        key_we       = 1'b0;
        key_wa       = r_slot;
        key_wd       = r_key;
        val_we       = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                key_we = 1'b1;
                key_wa = r_clr;
                key_wd = '0;
                n_clr  = r_clr + t_idx'(1);
                if (r_clr == IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd       = i_cmd.cmd;
                    n_key       = i_cmd.key;
                    n_value     = i_cmd.value;
                    n_slot      = mix[IDX_W-1:0];
                    n_probes    = '0;
                    n_res_found = '0;
                    if (i_cmd.cmd == CMD_INSERT && i_cmd.key == '0) begin
                        n_res_status = ST_ZERO_KEY;
                        n_state      = S_RESP;
                    end else if (i_cmd.cmd == CMD_INSERT && r_cnt == CNT_FULL) begin
                        n_res_status = ST_FULL;
                        n_state      = S_RESP;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_slot   = r_slot + t_idx'(1);
                n_probes = r_probes + t_idx'(1);
                n_state  = S_READ;
                if (r_cmd == CMD_INSERT) begin
                    if (r_rd_key == '0) begin
                        key_we       = 1'b1;
                        val_we       = 1'b1;
                        n_cnt        = r_cnt + t_cnt'(1);
                        n_res_status = ST_OK;
                        n_state      = S_RESP;
                    end else if (r_probes == IDX_LAST) begin
                        n_res_status = ST_FULL;
                        n_state      = S_RESP;
                    end
                end else begin
                    if (r_rd_key == '0) begin
                        n_res_status = ST_MISS;
                        n_state      = S_RESP;
                    end else if (r_rd_key == r_key) begin
                        n_res_status = ST_OK;
                        n_res_found  = r_rd_val;
                        n_state      = S_RESP;
                    end else if (r_probes == IDX_LAST) begin
                        n_res_status = ST_MISS;
                        n_state      = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_found  = r_res_found;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_probes     <= n_probes;
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_value      <= n_value;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            mem_key[key_wa] <= key_wd;
        end
        r_rd_key <= mem_key[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            mem_val[r_slot] <= r_value;
        end
        r_rd_val <= mem_val[r_slot];
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("entry count above table depth");

    a_cnt_only_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CHECK) |=> $stable(r_cnt))
        else $error("entry count changed outside a probe compare");

    a_no_zero_key_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (key_we && r_state == S_CHECK) |-> (r_key != '0))
        else $error("zero key written as an entry");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_found == '0))
        else $error("found value nonzero on a non-hit response");

    a_full_no_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_cmd.valid && i_cmd.cmd == CMD_INSERT && r_cnt == CNT_FULL)
        |=> (r_state == S_RESP && r_res_status != ST_OK))
        else $error("insert into full table started a probe");

endmodule
